// ===== design/nsp_pkg.sv =====
// Shared types, constants and helpers for the NMEA 0183 sentence parser.
// No dependencies; imported by nsp_step and nmea_sentence_parser_core.
package nsp_pkg;

	// Sizing of the (virtual) sentence buffer and field table
	localparam int BUFFER_SIZE = 128;
	localparam int MAX_FIELDS  = 32;

	// Next-free-slot counter must be able to hold BUFFER_SIZE itself
	localparam int WPOS_W = $clog2(BUFFER_SIZE + 1);
	localparam int ARGS_W = $clog2(MAX_FIELDS + 1);

	// Fixed port widths
	localparam int BYTE_W  = 8;
	localparam int EVENT_W = 4;
	localparam int FIDX_W  = 6;
	localparam int POS_W   = 7;
	localparam int FCNT_W  = 6;

	// Characters of interest
	localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
	localparam logic [BYTE_W-1:0] CH_COMMA  = 8'h2C;
	localparam logic [BYTE_W-1:0] CH_STAR   = 8'h2A;
	localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
	localparam logic [BYTE_W-1:0] CH_ZERO   = 8'h30;
	// 'A' - 10, so nibble 10 maps to 'A'
	localparam logic [BYTE_W-1:0] CH_HEXA_BASE = 8'h37;

	// Event codes on event_res
	typedef enum logic [EVENT_W-1:0] {
		EV_NONE      = 4'd0,
		EV_STRAY     = 4'd1,
		EV_START     = 4'd2,
		EV_FIELD     = 4'd3,
		EV_SEP       = 4'd4,
		EV_END       = 4'd5,
		EV_CK_OK     = 4'd6,
		EV_CK_ERR    = 4'd7,
		EV_CK_FOLLOW = 4'd8
	} event_t;

	// Parser phase, one-hot
	typedef enum logic [4:0] {
		PH_IDLE    = 5'b00001,
		PH_BODY    = 5'b00010,
		PH_CK1     = 5'b00100,
		PH_CK2     = 5'b01000,
		PH_DISCARD = 5'b10000
	} phase_t;

	// Architectural state carried from one byte to the next
	typedef struct packed {
		phase_t              phase;
		logic [BYTE_W-1:0]   xor_val;
		logic [WPOS_W-1:0]   wpos;
		logic [ARGS_W-1:0]   args;
		logic                ovf;
	} nsp_state_t;

	// One result item
	typedef struct packed {
		event_t              ev;
		logic [BYTE_W-1:0]   byte_out;
		logic [FIDX_W-1:0]   field_index;
		logic [POS_W-1:0]    position;
		logic [FCNT_W-1:0]   field_count;
		logic [BYTE_W-1:0]   checksum;
		logic                too_long;
	} nsp_result_t;

	// Uppercase ASCII hex digit for a nibble
	function automatic logic [BYTE_W-1:0] hex_char(input logic [3:0] nib);
		logic [BYTE_W-1:0] ext;
		ext = {4'b0000, nib};
		if (nib < 4'd10) begin
			return CH_ZERO + ext;
		end
		return CH_HEXA_BASE + ext;
	endfunction

endpackage

// ===== design/nsp_step.sv =====
// Next-state and result logic of the parser for one received byte.
// Purely combinational; depends on nsp_pkg.
module nsp_step import nsp_pkg::*; (
	input  logic [BYTE_W-1:0] rx_byte,
	input  nsp_state_t        cur,
	output nsp_state_t        nxt,
	output nsp_result_t       res
);

	localparam logic [WPOS_W-1:0] BUF_END  = WPOS_W'(BUFFER_SIZE);
	localparam logic [WPOS_W-1:0] BUF_LAST = WPOS_W'(BUFFER_SIZE - 1);
	localparam logic [ARGS_W-1:0] ARG_END  = ARGS_W'(MAX_FIELDS);

	event_t            ev;
	logic [BYTE_W-1:0] bo;
	logic [ARGS_W-1:0] fi;
	logic [WPOS_W-1:0] pos;
	logic              room;
	logic              field_room;
	logic [BYTE_W-1:0] want_hi;
	logic [BYTE_W-1:0] want_lo;

	assign room       = cur.wpos < BUF_END;
	assign field_room = cur.args < ARG_END;
	assign want_hi    = hex_char(cur.xor_val[7:4]);
	assign want_lo    = hex_char(cur.xor_val[3:0]);

	// Phase decode
	always_comb begin
		nxt = cur;
		ev  = EV_NONE;
		bo  = '0;
		fi  = '0;
		pos = '0;
		case (cur.phase)
			PH_BODY: begin
				if (rx_byte == CH_COMMA) begin
					nxt.xor_val = cur.xor_val ^ rx_byte;
					if (room && field_room) begin
						ev       = EV_SEP;
						fi       = cur.args;
						pos      = cur.wpos;
						nxt.wpos = cur.wpos + 1'b1;
						nxt.args = cur.args + 1'b1;
					end else begin
						nxt.ovf = 1'b1;
					end
				end else if (rx_byte == CH_STAR || rx_byte == CH_LF || rx_byte == CH_CR) begin
					// terminator takes the last slot when the buffer is full
					ev = (rx_byte == CH_STAR) ? EV_CK_FOLLOW : EV_END;
					fi = cur.args;
					if (room) begin
						pos      = cur.wpos;
						nxt.wpos = cur.wpos + 1'b1;
					end else begin
						pos     = BUF_LAST;
						nxt.ovf = 1'b1;
					end
					nxt.phase = (rx_byte == CH_STAR) ? PH_CK1 : PH_IDLE;
				end else begin
					nxt.xor_val = cur.xor_val ^ rx_byte;
					if (room) begin
						ev       = EV_FIELD;
						bo       = rx_byte;
						fi       = cur.args;
						pos      = cur.wpos;
						nxt.wpos = cur.wpos + 1'b1;
					end else begin
						nxt.ovf = 1'b1;
					end
				end
			end
			PH_CK1: begin
				if (rx_byte == CH_LF) begin
					ev        = EV_CK_ERR;
					nxt.phase = PH_IDLE;
				end else if (rx_byte == want_hi) begin
					nxt.phase = PH_CK2;
				end else begin
					// bad first digit: swallow the next byte
					ev        = EV_CK_ERR;
					nxt.phase = PH_DISCARD;
				end
			end
			PH_CK2: begin
				ev        = (rx_byte == want_lo) ? EV_CK_OK : EV_CK_ERR;
				nxt.phase = PH_IDLE;
			end
			PH_DISCARD: begin
				nxt.phase = PH_IDLE;
			end
			default: begin
				// idle, and any unused phase code
				if (rx_byte == CH_DOLLAR) begin
					ev          = EV_START;
					nxt.wpos    = '0;
					nxt.args    = '0;
					nxt.xor_val = '0;
					nxt.ovf     = 1'b0;
					nxt.phase   = PH_BODY;
				end else begin
					ev        = EV_STRAY;
					bo        = rx_byte;
					nxt.phase = PH_IDLE;
				end
			end
		endcase
	end

	// Result fields; running values are reported after this byte's update
	always_comb begin
		res.ev          = ev;
		res.byte_out    = bo;
		res.field_index = FIDX_W'(fi);
		res.position    = POS_W'(pos);
		res.field_count = FCNT_W'(nxt.args);
		res.checksum    = nxt.xor_val;
		res.too_long    = nxt.ovf;
	end

endmodule

// ===== design/nmea_sentence_parser_core.sv =====
// NMEA 0183 sentence parser: one byte in, one event out per transfer.
// A byte taken into the input register passes through nsp_step into the result
// register. Throughput: one byte per cycle while out_stall is low, since nsp_step
// updates the state combinationally; output stall holds both stages.
// Reset (arst_n low, asynchronous): both stages empty, parser idle, checksum,
// position, field count and overflow flag cleared.
module nmea_sentence_parser_core import nsp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [BYTE_W-1:0] rx_byte,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [EVENT_W-1:0] event_res,
	output logic [BYTE_W-1:0] byte_out,
	output logic [FIDX_W-1:0] field_index,
	output logic [POS_W-1:0]  position,
	output logic [FCNT_W-1:0] field_count,
	output logic [BYTE_W-1:0] checksum_value,
	output logic              too_long
);

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              valid_s2;
	nsp_result_t       res_s2;
	nsp_state_t        state_q;
	nsp_state_t        state_nxt;
	nsp_result_t       res_nxt;
	logic              adv;

	// Result register free or being drained this cycle
	assign adv      = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !adv;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= rx_byte;
		end
	end

	nsp_step u_step (
		.rx_byte (byte_s1),
		.cur     (state_q),
		.nxt     (state_nxt),
		.res     (res_nxt)
	);

	// Parser state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2      <= 1'b0;
			state_q.phase <= PH_IDLE;
			state_q.xor_val <= '0;
			state_q.wpos  <= '0;
			state_q.args  <= '0;
			state_q.ovf   <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				state_q <= state_nxt;
			end
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			res_s2 <= res_nxt;
		end
	end

	assign out_valid      = valid_s2;
	assign event_res      = res_s2.ev;
	assign byte_out       = res_s2.byte_out;
	assign field_index    = res_s2.field_index;
	assign position       = res_s2.position;
	assign field_count    = res_s2.field_count;
	assign checksum_value = res_s2.checksum;
	assign too_long       = res_s2.too_long;

	// Checks
	a_wpos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.wpos <= WPOS_W'(BUFFER_SIZE))
		else $error("write position beyond buffer size");

	a_args_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.args <= ARGS_W'(MAX_FIELDS))
		else $error("argument count beyond field limit");

	a_start_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.ev == EV_START) |->
		(!res_s2.too_long && res_s2.field_count == '0 && res_s2.checksum == '0))
		else $error("start event without cleared sentence state");

	a_sep_count: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.ev == EV_SEP) |->
		(res_s2.field_count == res_s2.field_index + 1'b1))
		else $error("separator does not advance field count");

endmodule

// ===== verif/tb_nmea_sentence_parser_core.sv =====
// Self-checking testbench for nmea_sentence_parser_core: directed and random NMEA byte streams.
// A byte-level parser model predicts every event. Depends on nsp_pkg and the core RTL only.
module tb_nmea_sentence_parser_core;
	import nsp_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned STREAM_BYTES  = 1350;
	localparam int unsigned TAIL_BYTES    = 150;
	localparam int unsigned DRAIN_CYCLES  = 8;
	localparam int unsigned STALL_LIMIT   = 2000;
	localparam int unsigned MAX_ERR_LINES = 40;

	typedef enum int {
		SHAPE_SHORT,
		SHAPE_LONG,
		SHAPE_WIDE
	} sentence_shape_t;

	logic               clk;
	logic               arst_n    = 1'b0;
	logic               in_valid  = 1'b0;
	logic               in_stall;
	logic [BYTE_W-1:0]  rx_byte   = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [EVENT_W-1:0] event_res;
	logic [BYTE_W-1:0]  byte_out;
	logic [FIDX_W-1:0]  field_index;
	logic [POS_W-1:0]   position;
	logic [FCNT_W-1:0]  field_count;
	logic [BYTE_W-1:0]  checksum_value;
	logic               too_long;

	nmea_sentence_parser_core u_dut (.*);

	// Stimulus bytes waiting for the driver, and events the parser still owes
	logic [BYTE_W-1:0] rx_stream[$];
	nsp_result_t       owed_events[$];
	nsp_result_t       head_event;

	// Parser model state
	phase_t            model_phase;
	logic [BYTE_W-1:0] model_xor;
	int unsigned       model_slot;
	int unsigned       model_args;
	logic              model_ovf;

	string hex_digits = "0123456789ABCDEF";

	int unsigned error_count  = 0;
	int unsigned bytes_sent   = 0;
	int unsigned events_seen  = 0;
	int unsigned overflow_events = 0;
	int unsigned event_tally[16];

	int unsigned in_gap   = 0;
	int unsigned out_gap  = 0;
	int unsigned in_mood  = 0;
	int unsigned out_mood = 0;
	logic        tail_phase = 1'b0;
	int unsigned idle_cycles = 0;
	int unsigned cycle_count = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [BYTE_W-1:0] upper_hex(input logic [3:0] nib);
		return hex_digits[nib];
	endfunction

	// Terminator slot; a full buffer pins it to the last slot
	function automatic int unsigned claim_terminator_slot();
		int unsigned slot;
		if (model_slot < BUFFER_SIZE) begin
			slot = model_slot;
			model_slot++;
		end else begin
			model_ovf = 1'b1;
			slot = BUFFER_SIZE - 1;
		end
		return slot;
	endfunction

	// Advance the parser model by one byte and return the event it yields
	function automatic nsp_result_t parse_byte(input logic [BYTE_W-1:0] c);
		nsp_result_t r;
		logic [BYTE_W-1:0] want_digit;
		r = '0;
		r.ev = EV_NONE;
		case (model_phase)
			PH_BODY: begin
				if (c == CH_COMMA) begin
					model_xor ^= c;
					if (model_slot < BUFFER_SIZE && model_args < MAX_FIELDS) begin
						r.ev = EV_SEP;
						r.field_index = FIDX_W'(model_args);
						r.position = POS_W'(model_slot);
						model_slot++;
						model_args++;
					end else begin
						model_ovf = 1'b1;
					end
				end else if (c == CH_STAR) begin
					r.ev = EV_CK_FOLLOW;
					r.field_index = FIDX_W'(model_args);
					r.position = POS_W'(claim_terminator_slot());
					model_phase = PH_CK1;
				end else if (c == CH_LF || c == CH_CR) begin
					r.ev = EV_END;
					r.field_index = FIDX_W'(model_args);
					r.position = POS_W'(claim_terminator_slot());
					model_phase = PH_IDLE;
				end else begin
					model_xor ^= c;
					if (model_slot < BUFFER_SIZE) begin
						r.ev = EV_FIELD;
						r.byte_out = c;
						r.field_index = FIDX_W'(model_args);
						r.position = POS_W'(model_slot);
						model_slot++;
					end else begin
						model_ovf = 1'b1;
					end
				end
			end
			PH_CK1: begin
				want_digit = upper_hex(model_xor[7:4]);
				if (c == CH_LF) begin
					r.ev = EV_CK_ERR;
					model_phase = PH_IDLE;
				end else if (c == want_digit) begin
					model_phase = PH_CK2;
				end else begin
					r.ev = EV_CK_ERR;
					model_phase = PH_DISCARD;
				end
			end
			PH_CK2: begin
				want_digit = upper_hex(model_xor[3:0]);
				r.ev = (c == want_digit) ? EV_CK_OK : EV_CK_ERR;
				model_phase = PH_IDLE;
			end
			PH_DISCARD: begin
				model_phase = PH_IDLE;
			end
			default: begin
				if (c == CH_DOLLAR) begin
					r.ev = EV_START;
					model_slot = 0;
					model_args = 0;
					model_xor = '0;
					model_ovf = 1'b0;
					model_phase = PH_BODY;
				end else begin
					r.ev = EV_STRAY;
					r.byte_out = c;
					model_phase = PH_IDLE;
				end
			end
		endcase
		r.field_count = FCNT_W'(model_args);
		r.checksum = model_xor;
		r.too_long = model_ovf;
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		if (error_count < MAX_ERR_LINES)
			$display("[%0t] MISMATCH: %s", $realtime, msg);
		error_count++;
	endtask

	task automatic check_field(input string name, input int unsigned got,
			input int unsigned want);
		if (got != want)
			report_mismatch($sformatf("event %0d %s got 0x%0h want 0x%0h",
				events_seen, name, got, want));
	endtask

	// One sentence: '$', body, then a checksum, a bare line end, or nothing
	task automatic queue_sentence(input sentence_shape_t shape);
		int unsigned       body_len;
		int unsigned       pick;
		logic [BYTE_W-1:0] body_xor;
		logic [BYTE_W-1:0] c;
		logic [BYTE_W-1:0] hi;
		logic [BYTE_W-1:0] lo;
		body_xor = '0;
		case (shape)
			SHAPE_LONG: body_len = $urandom_range(124, 140);
			SHAPE_WIDE: body_len = $urandom_range(60, 90);
			default:    body_len = $urandom_range(0, 24);
		endcase
		rx_stream.push_back(CH_DOLLAR);
		for (int i = 0; i < body_len; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < ((shape == SHAPE_WIDE) ? 50 : 18)) begin
				c = CH_COMMA;
			end else if (pick < 32) begin
				do c = BYTE_W'($urandom);
				while (c == CH_STAR || c == CH_LF || c == CH_CR);
			end else begin
				do c = BYTE_W'($urandom_range(8'h20, 8'h7E));
				while (c == CH_STAR);
			end
			body_xor ^= c;
			rx_stream.push_back(c);
		end
		pick = $urandom_range(0, 99);
		// truncated sentence: the next '$' lands in the body
		if (pick < 6)
			return;
		if (pick < 20) begin
			rx_stream.push_back($urandom_range(0, 1) ? CH_CR : CH_LF);
		end else begin
			rx_stream.push_back(CH_STAR);
			hi = upper_hex(body_xor[7:4]);
			lo = upper_hex(body_xor[3:0]);
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				rx_stream.push_back(hi);
				rx_stream.push_back(lo);
			end else if (pick < 76) begin
				rx_stream.push_back(hi);
				rx_stream.push_back(lo ^ 8'h01);
			end else if (pick < 82) begin
				// wrong first digit, the second one is swallowed
				rx_stream.push_back(hi ^ 8'h01);
				rx_stream.push_back(lo);
			end else if (pick < 88) begin
				// lowercase letters never match
				rx_stream.push_back(hi | 8'h20);
				rx_stream.push_back(lo | 8'h20);
			end else if (pick < 94) begin
				rx_stream.push_back(CH_LF);
			end else begin
				rx_stream.push_back(CH_CR);
				rx_stream.push_back(BYTE_W'($urandom));
			end
		end
		if ($urandom_range(0, 1)) begin
			rx_stream.push_back(CH_CR);
			rx_stream.push_back(CH_LF);
		end
	endtask

	function automatic bit start_idle(input int unsigned mood);
		case (mood)
			0:       return 1'b0;
			1:       return $urandom_range(0, 11) == 0;
			default: return $urandom_range(0, 2) == 0;
		endcase
	endfunction

	// Driver: predicts on each input transfer, then picks the next byte or a gap
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				owed_events.push_back(parse_byte(rx_byte));
				bytes_sent++;
			end
			tail_phase <= (rx_stream.size() < TAIL_BYTES);
			if (in_valid && in_stall) begin
				// hold the stalled byte
			end else if (in_gap > 0) begin
				in_valid <= 1'b0;
				in_gap <= in_gap - 1;
			end else if (rx_stream.size() >= TAIL_BYTES && start_idle(in_mood)) begin
				in_valid <= 1'b0;
				in_gap <= $urandom_range(0, 16);
			end else if (rx_stream.size() != 0) begin
				in_valid <= 1'b1;
				rx_byte <= rx_stream.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Monitor: checks each output transfer against the oldest owed event
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (owed_events.size() == 0) begin
					report_mismatch($sformatf("result with nothing owed, event_res %0d",
						event_res));
				end else begin
					head_event = owed_events.pop_front();
					check_field("event_res", event_res, head_event.ev);
					check_field("byte_out", byte_out, head_event.byte_out);
					check_field("field_index", field_index, head_event.field_index);
					check_field("position", position, head_event.position);
					check_field("field_count", field_count, head_event.field_count);
					check_field("checksum_value", checksum_value, head_event.checksum);
					check_field("too_long", too_long, head_event.too_long);
				end
				event_tally[event_res]++;
				if (too_long)
					overflow_events++;
				events_seen++;
			end
			if (out_gap > 0) begin
				out_stall <= 1'b1;
				out_gap <= out_gap - 1;
			end else if (!tail_phase && start_idle(out_mood)) begin
				out_stall <= 1'b1;
				out_gap <= $urandom_range(0, 16);
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Idle moods are redrawn at regular intervals of cycle_count; watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (arst_n) begin
			cycle_count++;
			if (cycle_count % 128 == 0) begin
				in_mood <= $urandom_range(0, 2);
				out_mood <= $urandom_range(0, 2);
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("[%0t] watchdog: no transfer for %0d cycles", $realtime,
					STALL_LIMIT);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	initial begin
		model_phase = PH_IDLE;
		model_xor = '0;
		model_slot = 0;
		model_args = 0;
		model_ovf = 1'b0;
		foreach (event_tally[i])
			event_tally[i] = 0;

		// Directed: stray extremes, good checksum, CR and LF ends, LF and CR as
		// first digit (the latter swallows a byte), wrong second digit
		rx_stream = {8'h00, 8'hFF,
			CH_DOLLAR, 8'h41, CH_COMMA, 8'h80, CH_STAR, 8'h45, 8'h44,
			CH_DOLLAR, 8'h42, CH_CR,
			CH_DOLLAR, CH_LF,
			CH_DOLLAR, CH_STAR, CH_LF,
			CH_DOLLAR, CH_STAR, CH_CR, 8'h58,
			CH_DOLLAR, CH_STAR, 8'h30, 8'h78};

		// Random sentences; buffer and field overflow provoked early, then rare
		for (int s = 0; rx_stream.size() < STREAM_BYTES; s++) begin
			if ($urandom_range(0, 9) == 0) begin
				repeat ($urandom_range(1, 4))
					rx_stream.push_back(BYTE_W'($urandom));
			end
			if (s == 0)
				queue_sentence(SHAPE_LONG);
			else if (s == 1)
				queue_sentence(SHAPE_WIDE);
			else if ($urandom_range(0, 99) < 3)
				queue_sentence(SHAPE_LONG);
			else if ($urandom_range(0, 99) < 3)
				queue_sentence(SHAPE_WIDE);
			else
				queue_sentence(SHAPE_SHORT);
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		@(negedge clk);
		while (rx_stream.size() != 0 || in_valid || owed_events.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (owed_events.size() != 0)
			report_mismatch($sformatf("%0d events never arrived", owed_events.size()));

		$display("Ran %0d bytes, %0d events: %0d checksum ok, %0d checksum errors, %0d unchecked ends",
			bytes_sent, events_seen, event_tally[EV_CK_OK], event_tally[EV_CK_ERR],
			event_tally[EV_END]);
		$display("Starts %0d, strays %0d, separators %0d, events with too_long set %0d",
			event_tally[EV_START], event_tally[EV_STRAY], event_tally[EV_SEP],
			overflow_events);
		if (error_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
